@@ hw/rtl/lr3d_pkg.sv @@
// Shared types and constants for the 3D line rasterizer.
`default_nettype none
package lr3d_pkg;

	localparam int CoordW = 6;
	localparam int ErrW = CoordW + 3;
	localparam int QueueDepth = 2;
	localparam int NumAxes = 3;

	typedef logic [CoordW-1:0] coord_t;
	typedef logic signed [ErrW-1:0] err_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	// One classified line, handed from the front end to the walker.
	typedef struct packed {
		coord_t [NumAxes-1:0] start;
		coord_t [NumAxes-1:0] stop;
		coord_t [NumAxes-1:0] delta;
		logic [NumAxes-1:0] neg;
		axis_t major;
		coord_t big;
	} job_t;

endpackage
`default_nettype wire

@@ hw/rtl/lr3d_front.sv @@
// Front end: masks endpoints, computes deltas and directions, picks the major axis.
`default_nettype none
module lr3d_front #(
	parameter int COORD_BITS = 6
) (
	input wire logic [5:0] start_x,
	input wire logic [5:0] start_y,
	input wire logic [5:0] start_z,
	input wire logic [5:0] end_x,
	input wire logic [5:0] end_y,
	input wire logic [5:0] end_z,
	output lr3d_pkg::job_t job
);

	localparam lr3d_pkg::coord_t CoordMask = lr3d_pkg::CoordW'((1 << COORD_BITS) - 1);

	lr3d_pkg::coord_t [lr3d_pkg::NumAxes-1:0] s;
	lr3d_pkg::coord_t [lr3d_pkg::NumAxes-1:0] e;
	lr3d_pkg::coord_t [lr3d_pkg::NumAxes-1:0] d;
	logic [lr3d_pkg::NumAxes-1:0] neg;
	logic gt01;

	always_comb begin
		s[0] = start_x & CoordMask;
		s[1] = start_y & CoordMask;
		s[2] = start_z & CoordMask;
		e[0] = end_x & CoordMask;
		e[1] = end_y & CoordMask;
		e[2] = end_z & CoordMask;
		for (int a = 0; a < lr3d_pkg::NumAxes; a++) begin
			neg[a] = (e[a] < s[a]);
			d[a] = neg[a] ? (s[a] - e[a]) : (e[a] - s[a]);
		end
	end

	always_comb begin
		gt01 = (d[0] > d[1]);
		job.start = s;
		job.stop = e;
		job.delta = d;
		job.neg = neg;
		// X wins only when strictly above both; Y only when X is not above it.
		priority if (gt01 && (d[0] > d[2])) begin
			job.major = lr3d_pkg::AXIS_X;
			job.big = d[0];
		end else if (!gt01 && (d[1] > d[2])) begin
			job.major = lr3d_pkg::AXIS_Y;
			job.big = d[1];
		end else begin
			job.major = lr3d_pkg::AXIS_Z;
			job.big = d[2];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/lr3d_queue.sv @@
// Small FIFO of classified lines between the front end and the walker.
`default_nettype none
module lr3d_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire lr3d_pkg::job_t push_data,
	output logic pop_valid,
	input wire logic pop_ready,
	output lr3d_pkg::job_t pop_data
);

	localparam int PtrW = (lr3d_pkg::QueueDepth > 1) ? $clog2(lr3d_pkg::QueueDepth) : 1;
	localparam int CntW = $clog2(lr3d_pkg::QueueDepth + 1);

	lr3d_pkg::job_t entries_q [lr3d_pkg::QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != CntW'(lr3d_pkg::QueueDepth));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(lr3d_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(lr3d_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/lr3d_back.sv @@
// Walker: steps one voxel per cycle while the output is not stalled, with integer error terms into an output register.
`default_nettype none
module lr3d_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	output logic job_ready,
	input wire lr3d_pkg::job_t job,
	output logic out_valid,
	input wire logic out_ready,
	output logic [5:0] out_x,
	output logic [5:0] out_y,
	output logic [5:0] out_z,
	output logic is_last
);

	lr3d_pkg::job_t job_q;
	logic busy_q;
	lr3d_pkg::coord_t remain_q;
	lr3d_pkg::coord_t [lr3d_pkg::NumAxes-1:0] cur_q;
	lr3d_pkg::err_t [lr3d_pkg::NumAxes-1:0] err_q;
	lr3d_pkg::coord_t [lr3d_pkg::NumAxes-1:0] cur_nxt;
	lr3d_pkg::err_t [lr3d_pkg::NumAxes-1:0] err_nxt;
	logic out_valid_q;
	lr3d_pkg::coord_t out_x_q;
	lr3d_pkg::coord_t out_y_q;
	lr3d_pkg::coord_t out_z_q;
	logic is_last_q;
	logic emit;
	logic final_pt;
	logic pop;

	assign final_pt = (remain_q == '0);
	assign emit = busy_q && (!out_valid_q || out_ready);
	assign pop = job_valid && (!busy_q || (emit && final_pt));
	assign job_ready = !busy_q || (emit && final_pt);

	for (genvar a = 0; a < lr3d_pkg::NumAxes; a++) begin : g_axis
		localparam lr3d_pkg::axis_t Ax = lr3d_pkg::axis_t'(a);
		lr3d_pkg::err_t err_sum;
		logic is_major;
		logic ge;
		logic step;

		always_comb begin
			is_major = (job_q.major == Ax);
			err_sum = err_q[a] + $signed({2'b00, job_q.delta[a], 1'b0});
			ge = (err_sum >= $signed({3'b000, job_q.big}));
			step = is_major || ge;
			cur_nxt[a] = step ? (job_q.neg[a] ? cur_q[a] - 1'b1 : cur_q[a] + 1'b1) : cur_q[a];
			err_nxt[a] = (!is_major && ge) ? err_sum - $signed({2'b00, job_q.big, 1'b0}) : err_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
			cur_q <= job.start;
			err_q <= '0;
			remain_q <= job.big;
		end else if (emit && !final_pt) begin
			cur_q <= cur_nxt;
			err_q <= err_nxt;
			remain_q <= remain_q - 1'b1;
		end
		if (emit) begin
			out_x_q <= final_pt ? job_q.stop[0] : cur_q[0];
			out_y_q <= final_pt ? job_q.stop[1] : cur_q[1];
			out_z_q <= final_pt ? job_q.stop[2] : cur_q[2];
			is_last_q <= final_pt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (emit && final_pt) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_z = out_z_q;
	assign is_last = is_last_q;

endmodule
`default_nettype wire

@@ hw/rtl/line_rasterizer_3d_core.sv @@
// Top level of the 3D line rasterizer: front end, line queue and voxel walker.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   start_x start_y start_z end_x end_y end_z
//   output    out_valid / out_ready out_x out_y out_z is_last
//
// A line with major delta D produces D + 1 voxels (1 to 64), one per cycle while
// the output is not stalled; the walker's single stepping loop produces them.
// An idle walker first loads a line from the queue before it steps it.
// Reset clears the queue pointers and count, the busy flag and the output valid; nothing else.
// A stall on the output freezes the walker while the queue still takes requests until it is full.
`default_nettype none
module line_rasterizer_3d_core #(
	parameter int COORD_BITS = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [5:0] start_x,
	input wire logic [5:0] start_y,
	input wire logic [5:0] start_z,
	input wire logic [5:0] end_x,
	input wire logic [5:0] end_y,
	input wire logic [5:0] end_z,
	output logic out_valid,
	input wire logic out_ready,
	output logic [5:0] out_x,
	output logic [5:0] out_y,
	output logic [5:0] out_z,
	output logic is_last
);

	// Classified request as it enters the queue, and as it leaves it.
	lr3d_pkg::job_t front_job;
	lr3d_pkg::job_t queue_job;
	logic queue_valid;
	logic walker_ready;

	// The front end is pure logic; a request is accepted when the queue has room.
	lr3d_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.start_x(start_x),
		.start_y(start_y),
		.start_z(start_z),
		.end_x(end_x),
		.end_y(end_y),
		.end_z(end_z),
		.job(front_job)
	);

	// The queue lets new requests land while the walker is still stepping.
	lr3d_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(in_valid),
		.push_ready(in_ready),
		.push_data(front_job),
		.pop_valid(queue_valid),
		.pop_ready(walker_ready),
		.pop_data(queue_job)
	);

	// The walker takes the next line in the same cycle as it emits the end point.
	lr3d_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(queue_valid),
		.job_ready(walker_ready),
		.job(queue_job),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.is_last(is_last)
	);

endmodule
`default_nettype wire
